/* hw/rtl/lr4_pkg.sv */
// Shared types and register map for the fourth-order Linkwitz-Riley lowpass.
package lr4_pkg;

    localparam int COEF_BITS    = 32;
    localparam int CHAN_BITS    = 3;
    localparam int CFG_IDX_BITS = 3;
    localparam int NUM_COEFS    = 7;

    typedef logic signed [COEF_BITS-1:0] coef_t;
    typedef logic [CHAN_BITS-1:0]        chan_t;
    typedef logic [CFG_IDX_BITS-1:0]     cfg_idx_t;

    // Coefficient register indexes
    localparam cfg_idx_t COEF_A0 = 3'd0;
    localparam cfg_idx_t COEF_A1 = 3'd1;
    localparam cfg_idx_t COEF_A2 = 3'd2;
    localparam cfg_idx_t COEF_B1 = 3'd3;
    localparam cfg_idx_t COEF_B2 = 3'd4;
    localparam cfg_idx_t COEF_B3 = 3'd5;
    localparam cfg_idx_t COEF_B4 = 3'd6;

endpackage

/* hw/rtl/linkwitz_riley4_lowpass.sv */
// Multichannel fourth-order Linkwitz-Riley lowpass, direct form I, fixed point.
// Throughput: one transaction per cycle unless m_ready stalls the output; set by the
//   single compute stage that reads the channel's delay registers, runs seven parallel
//   multiplies and writes the state back.
// Reset (aresetn low, synchronous): coefficients and all channel delay lines go to zero,
//   both pipeline registers are emptied.
module linkwitz_riley4_lowpass
    import lr4_pkg::*;
#(
    parameter int CHANNELS       = 8,
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 28
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    // Coefficient write port
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  cfg_idx_t               cfg_index,
    input  coef_t                  cfg_data,

    // Sample input
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [SAMPLE_BITS-1:0] s_sample_in,
    input  chan_t                  s_chan_in,

    // Filtered output
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [SAMPLE_BITS-1:0] m_filtered_out,
    output chan_t                  m_chan_out
);

    // Only channels reachable through the channel field get storage.
    localparam int MAX_CHAN = 1 << CHAN_BITS;
    localparam int DEPTH    = (CHANNELS < MAX_CHAN) ? CHANNELS : MAX_CHAN;
    localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Datapath widths: tap sums carry one extra bit, seven products plus
    // rounding need three guard bits on top of the product.
    localparam int SUM_W  = SAMPLE_BITS + 1;
    localparam int PROD_W = COEF_BITS + SUM_W;
    localparam int ACC_W  = PROD_W + 3;
    localparam int SH_W   = ACC_W - COEF_FRAC_BITS;

    localparam logic signed [ACC_W-1:0] ROUND_C =
        {{(ACC_W-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};
    localparam logic signed [SH_W-1:0] SAT_MAX =
        SH_W'($signed({1'b0, {(SAMPLE_BITS-1){1'b1}}}));
    localparam logic signed [SH_W-1:0] SAT_MIN =
        SH_W'($signed({1'b1, {(SAMPLE_BITS-1){1'b0}}}));

    // ------------------------------------------------------------------
    // Coefficient registers. Writes always complete; indexes past the
    // last coefficient are dropped.
    // ------------------------------------------------------------------
    coef_t coef_reg [NUM_COEFS];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_COEFS; i++) begin
                coef_reg[i] <= '0;
            end
        end else if (cfg_valid && (int'(cfg_index) < NUM_COEFS)) begin
            coef_reg[cfg_index] <= cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // Input register. It advances whenever the output register is free
    // or being drained this cycle, so one transaction moves per cycle.
    // ------------------------------------------------------------------
    logic                   in_valid_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    chan_t                  chan_reg;
    logic                   out_valid_reg;
    logic                   advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            sample_reg <= s_sample_in;
            chan_reg   <= s_chan_in;
        end
    end

    // ------------------------------------------------------------------
    // Per-channel delay lines: four past inputs, four past outputs.
    // ------------------------------------------------------------------
    logic [SAMPLE_BITS-1:0] xd1_reg [DEPTH];
    logic [SAMPLE_BITS-1:0] xd2_reg [DEPTH];
    logic [SAMPLE_BITS-1:0] xd3_reg [DEPTH];
    logic [SAMPLE_BITS-1:0] xd4_reg [DEPTH];
    logic [SAMPLE_BITS-1:0] yd1_reg [DEPTH];
    logic [SAMPLE_BITS-1:0] yd2_reg [DEPTH];
    logic [SAMPLE_BITS-1:0] yd3_reg [DEPTH];
    logic [SAMPLE_BITS-1:0] yd4_reg [DEPTH];

    // Out-of-range channels leave state alone and produce zero.
    logic             in_range;
    logic [IDX_W-1:0] rd_idx;

    assign in_range = int'(chan_reg) < CHANNELS;
    assign rd_idx   = in_range ? chan_reg[IDX_W-1:0] : '0;

    // ------------------------------------------------------------------
    // Compute: symmetric taps are pre-added, then seven multiplies feed
    // one adder tree, round half up, arithmetic shift and clamp.
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0]  sum_a0, sum_a1, sum_a2;
    logic signed [SUM_W-1:0]  tap_y1, tap_y2, tap_y3, tap_y4;
    logic signed [PROD_W-1:0] prod_a0, prod_a1, prod_a2;
    logic signed [PROD_W-1:0] prod_b1, prod_b2, prod_b3, prod_b4;
    logic signed [ACC_W-1:0]  acc;
    logic signed [SH_W-1:0]   acc_shift;
    logic [SAMPLE_BITS-1:0]   y_sat;

    assign sum_a0 = SUM_W'($signed(sample_reg)) + SUM_W'($signed(xd4_reg[rd_idx]));
    assign sum_a1 = SUM_W'($signed(xd1_reg[rd_idx])) + SUM_W'($signed(xd3_reg[rd_idx]));
    assign sum_a2 = SUM_W'($signed(xd2_reg[rd_idx]));
    assign tap_y1 = SUM_W'($signed(yd1_reg[rd_idx]));
    assign tap_y2 = SUM_W'($signed(yd2_reg[rd_idx]));
    assign tap_y3 = SUM_W'($signed(yd3_reg[rd_idx]));
    assign tap_y4 = SUM_W'($signed(yd4_reg[rd_idx]));

    assign prod_a0 = PROD_W'(coef_reg[COEF_A0]) * PROD_W'(sum_a0);
    assign prod_a1 = PROD_W'(coef_reg[COEF_A1]) * PROD_W'(sum_a1);
    assign prod_a2 = PROD_W'(coef_reg[COEF_A2]) * PROD_W'(sum_a2);
    assign prod_b1 = PROD_W'(coef_reg[COEF_B1]) * PROD_W'(tap_y1);
    assign prod_b2 = PROD_W'(coef_reg[COEF_B2]) * PROD_W'(tap_y2);
    assign prod_b3 = PROD_W'(coef_reg[COEF_B3]) * PROD_W'(tap_y3);
    assign prod_b4 = PROD_W'(coef_reg[COEF_B4]) * PROD_W'(tap_y4);

    assign acc = ACC_W'(prod_a0) + ACC_W'(prod_a1) + ACC_W'(prod_a2)
               - ACC_W'(prod_b1) - ACC_W'(prod_b2) - ACC_W'(prod_b3)
               - ACC_W'(prod_b4) + ROUND_C;

    assign acc_shift = SH_W'(acc >>> COEF_FRAC_BITS);

    always_comb begin
        if (acc_shift > SAT_MAX) begin
            y_sat = SAT_MAX[SAMPLE_BITS-1:0];
        end else if (acc_shift < SAT_MIN) begin
            y_sat = SAT_MIN[SAMPLE_BITS-1:0];
        end else begin
            y_sat = acc_shift[SAMPLE_BITS-1:0];
        end
    end

    // State write-back happens on the same edge the result is registered,
    // so a following sample of the same channel sees the new history.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) begin
                xd1_reg[i] <= '0;
                xd2_reg[i] <= '0;
                xd3_reg[i] <= '0;
                xd4_reg[i] <= '0;
                yd1_reg[i] <= '0;
                yd2_reg[i] <= '0;
                yd3_reg[i] <= '0;
                yd4_reg[i] <= '0;
            end
        end else if (advance && in_range) begin
            xd4_reg[rd_idx] <= xd3_reg[rd_idx];
            xd3_reg[rd_idx] <= xd2_reg[rd_idx];
            xd2_reg[rd_idx] <= xd1_reg[rd_idx];
            xd1_reg[rd_idx] <= sample_reg;
            yd4_reg[rd_idx] <= yd3_reg[rd_idx];
            yd3_reg[rd_idx] <= yd2_reg[rd_idx];
            yd2_reg[rd_idx] <= yd1_reg[rd_idx];
            yd1_reg[rd_idx] <= y_sat;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [SAMPLE_BITS-1:0] filtered_reg;
    chan_t                  chan_out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            filtered_reg <= in_range ? y_sat : '0;
            chan_out_reg <= chan_reg;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_filtered_out = filtered_reg;
    assign m_chan_out     = chan_out_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // A moving transaction lands in the output register with its channel.
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg && (chan_out_reg == $past(chan_reg)))
        else $error("result register did not capture the advancing transaction");

    // Channels without state always report zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && (int'(chan_out_reg) >= CHANNELS)) |-> (filtered_reg == '0))
        else $error("out-of-range channel produced a nonzero sample");

    // The newest output history entry matches the sample just emitted.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_range) |=> (yd1_reg[$past(rd_idx)] == filtered_reg))
        else $error("output delay line out of step with emitted sample");

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for the multichannel fourth-order Linkwitz-Riley lowpass.
`timescale 1ns / 100ps

import lr4_pkg::*;

// Scoreboard: keeps its own copy of the coefficients and of every channel's
// delay lines, predicts each filtered sample and checks the output stream in order.
class lr4_sample_checker #(int CHANNELS = 8, int SAMPLE_BITS = 24, int FRAC_BITS = 28);
    typedef logic signed [SAMPLE_BITS-1:0] smp_t;
    typedef logic signed [SAMPLE_BITS:0]   pair_t;
    typedef logic signed [79:0]            acc_t;
    typedef struct packed {
        smp_t  filtered;
        chan_t chan;
    } filtered_t;

    coef_t     coef [NUM_COEFS];
    smp_t      x1 [CHANNELS], x2 [CHANNELS], x3 [CHANNELS], x4 [CHANNELS];
    smp_t      y1 [CHANNELS], y2 [CHANNELS], y3 [CHANNELS], y4 [CHANNELS];
    filtered_t pending_filtered [$];
    int        mismatches;

    function new();
        foreach (coef[i]) coef[i] = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            x1[c] = '0; x2[c] = '0; x3[c] = '0; x4[c] = '0;
            y1[c] = '0; y2[c] = '0; y3[c] = '0; y4[c] = '0;
        end
        mismatches = 0;
    endfunction

    function void write_coef(cfg_idx_t idx, coef_t val);
        if (idx < NUM_COEFS) coef[idx] = val;
    endfunction

    function acc_t product(coef_t c, pair_t s);
        acc_t cw, sw;
        cw = c;
        sw = s;
        return cw * sw;
    endfunction

    // One direct-form-I step: full-width sum, round half up, clamp, shift delays.
    function smp_t filter_step(smp_t x, chan_t ch);
        acc_t acc, half, hi_lim, lo_lim;
        if (ch >= CHANNELS) return '0;
        acc = product(coef[COEF_A0], x + x4[ch])
            + product(coef[COEF_A1], x1[ch] + x3[ch])
            + product(coef[COEF_A2], x2[ch])
            - product(coef[COEF_B1], y1[ch])
            - product(coef[COEF_B2], y2[ch])
            - product(coef[COEF_B3], y3[ch])
            - product(coef[COEF_B4], y4[ch]);
        half = 1;
        half = half <<< (FRAC_BITS - 1);
        acc = (acc + half) >>> FRAC_BITS;
        hi_lim = 1;
        hi_lim = (hi_lim <<< (SAMPLE_BITS - 1)) - 1;
        lo_lim = -hi_lim - 1;
        if (acc > hi_lim) acc = hi_lim;
        else if (acc < lo_lim) acc = lo_lim;
        x4[ch] = x3[ch]; x3[ch] = x2[ch]; x2[ch] = x1[ch]; x1[ch] = x;
        y4[ch] = y3[ch]; y3[ch] = y2[ch]; y2[ch] = y1[ch]; y1[ch] = acc[SAMPLE_BITS-1:0];
        return acc[SAMPLE_BITS-1:0];
    endfunction

    function void note_sample(smp_t x, chan_t ch);
        filtered_t e;
        e.filtered = filter_step(x, ch);
        e.chan     = ch;
        pending_filtered.push_back(e);
    endfunction

    function void check_filtered(smp_t got, chan_t ch);
        filtered_t e;
        if (pending_filtered.size() == 0) begin
            $error("unexpected output sample %0d on channel %0d", got, ch);
            mismatches++;
            return;
        end
        e = pending_filtered.pop_front();
        if (got !== e.filtered) begin
            $error("filtered_out: expected %0d, actual %0d", e.filtered, got);
            mismatches++;
        end
        if (ch !== e.chan) begin
            $error("chan_out: expected %0d, actual %0d", e.chan, ch);
            mismatches++;
        end
    endfunction

    function int pending();
        return pending_filtered.size();
    endfunction
endclass

module tb_top;

    localparam int CHANNELS       = 8;
    localparam int SAMPLE_BITS    = 24;
    localparam int COEF_FRAC_BITS = 28;

    // Run limit, far above the slowest legal run (about 850 samples, each
    // possibly waiting out a receiver hold plus sender gaps).
    localparam int CYCLE_LIMIT  = 400000;
    // Extra cycles waited after the last expected sample has come out, letting the pipe settle.
    localparam int DRAIN_CYCLES = 4;

    localparam cfg_idx_t CFG_IDX_SPARE = 3'd7;   // unmapped index, must be ignored

    localparam coef_t COEF_MAX  = 32'sh7FFF_FFFF;
    localparam coef_t COEF_MIN  = 32'sh8000_0000;
    localparam coef_t COEF_ONE  = 32'sh1000_0000;  // 1.0 in Q4.28
    localparam coef_t COEF_HALF = 32'sh0800_0000;  // 0.5 in Q4.28

    localparam logic [SAMPLE_BITS-1:0] SMP_MAX = 24'h7F_FFFF;
    localparam logic [SAMPLE_BITS-1:0] SMP_MIN = 24'h80_0000;

    // Coefficient sets used by the random phases
    typedef enum int {
        SET_SMOOTH,        // binomial FIR, no feedback
        SET_RESONANT,      // moderate feedback
        SET_RANDOM_FULL,   // anything in Q4.28, mostly saturates
        SET_RANDOM_UNIT,   // random gains within +/-1.0
        SET_PASS           // a0 = 1.0 plus a small fourth-order feedback
    } coef_set_t;

    // Receiver back-pressure patterns
    typedef enum int {
        READY_ALWAYS,
        READY_COIN,
        READY_ONE_IN_FOUR,
        READY_MOSTLY,
        READY_HOLD
    } ready_mode_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_valid;
    logic                   cfg_ready;
    cfg_idx_t               cfg_index;
    coef_t                  cfg_data;
    logic                   s_valid;
    logic                   s_ready;
    logic [SAMPLE_BITS-1:0] s_sample_in;
    chan_t                  s_chan_in;
    logic                   m_valid;
    logic                   m_ready;
    logic [SAMPLE_BITS-1:0] m_filtered_out;
    chan_t                  m_chan_out;

    lr4_sample_checker #(.CHANNELS(CHANNELS), .SAMPLE_BITS(SAMPLE_BITS),
                         .FRAC_BITS(COEF_FRAC_BITS)) filter_sb;

    coef_t       next_coefs [NUM_COEFS];
    int          cycle_count;
    ready_mode_t ready_mode;
    int          ready_left;

    linkwitz_riley4_lowpass #(
        .CHANNELS       (CHANNELS),
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample_in    (s_sample_in),
        .s_chan_in      (s_chan_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_filtered_out (m_filtered_out),
        .m_chan_out     (m_chan_out)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL linkwitz_riley4_lowpass");
            $finish;
        end
    end

    // Receiver: switches between back-pressure patterns at random intervals,
    // including stretches that are always ready and stretches held off entirely.
    always @(posedge aclk) begin
        if (ready_left == 0) begin
            ready_mode <= ready_mode_t'($urandom_range(READY_ALWAYS, READY_HOLD));
            ready_left <= $urandom_range(8, 80);
        end else begin
            ready_left <= ready_left - 1;
        end
        case (ready_mode)
            READY_ALWAYS:      m_ready <= 1'b1;
            READY_COIN:        m_ready <= ($urandom_range(0, 1) == 1);
            READY_ONE_IN_FOUR: m_ready <= (cycle_count % 4 == 0);
            READY_MOSTLY:      m_ready <= ($urandom_range(0, 7) != 0);
            default:           m_ready <= 1'b0;
        endcase
    end

    // Monitor: every transaction on the three channels goes to the scoreboard.
    // Inputs are noted before outputs are checked, keeping queue order intact.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) filter_sb.write_coef(cfg_index, cfg_data);
            if (s_valid && s_ready) filter_sb.note_sample(s_sample_in, s_chan_in);
            if (m_valid && m_ready) filter_sb.check_filtered(m_filtered_out, m_chan_out);
        end
    end

    // Offer one sample and hold it until the block takes it. Valid stays high
    // on return so back-to-back samples can follow without a gap.
    task automatic send_sample(logic [SAMPLE_BITS-1:0] sample, chan_t chan);
        s_valid     <= 1'b1;
        s_sample_in <= sample;
        s_chan_in   <= chan;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Register write; valid is left high for the next write, caller lowers it.
    task automatic write_reg(cfg_idx_t idx, coef_t val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Write all seven coefficients plus a junk write to the unmapped index.
    task automatic load_coefs();
        for (int i = 0; i < NUM_COEFS; i++) write_reg(cfg_idx_t'(i), next_coefs[i]);
        write_reg(CFG_IDX_SPARE, coef_t'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // Wait for every predicted sample to come out, then let the pipe settle.
    // The first edge makes sure the last accepted sample is already noted.
    task automatic drain_results();
        @(posedge aclk);
        while (filter_sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [SAMPLE_BITS-1:0] random_sample();
        case ($urandom_range(0, 9))
            0:       return SMP_MAX;
            1:       return SMP_MIN;
            2, 3, 4: return SAMPLE_BITS'($urandom_range(0, 511) - 256);
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    function automatic coef_t unit_coef();
        return coef_t'($urandom_range(0, 32'h2000_0000)) - COEF_ONE;
    endfunction

    task automatic choose_setting(coef_set_t kind);
        foreach (next_coefs[i]) next_coefs[i] = '0;
        case (kind)
            SET_SMOOTH: begin
                // (1 4 6 4 1)/16 smoothing kernel
                next_coefs[COEF_A0] = COEF_ONE >>> 4;
                next_coefs[COEF_A1] = COEF_ONE >>> 2;
                next_coefs[COEF_A2] = (COEF_ONE >>> 3) * 3;
            end
            SET_RESONANT: begin
                next_coefs[COEF_A0] = COEF_ONE >>> 4;
                next_coefs[COEF_A1] = COEF_ONE >>> 4;
                next_coefs[COEF_A2] = COEF_ONE >>> 4;
                next_coefs[COEF_B1] = -COEF_HALF;
                next_coefs[COEF_B2] = COEF_ONE >>> 3;
                next_coefs[COEF_B3] = -(COEF_ONE >>> 4);
                next_coefs[COEF_B4] = COEF_ONE >>> 5;
            end
            SET_RANDOM_FULL: begin
                foreach (next_coefs[i]) next_coefs[i] = coef_t'($urandom);
            end
            SET_RANDOM_UNIT: begin
                foreach (next_coefs[i]) next_coefs[i] = unit_coef();
            end
            default: begin
                next_coefs[COEF_A0] = COEF_ONE;
                next_coefs[COEF_B4] = COEF_ONE >>> 2;
            end
        endcase
    endtask

    // Random traffic in bursts of random length with random gaps; some bursts
    // stay on one channel to build up deep per-channel history.
    task automatic send_bursts(int n_items);
        int    sent, burst, gap;
        chan_t chan;
        sent = 0;
        while (sent < n_items) begin
            burst = $urandom_range(1, 12);
            chan  = chan_t'($urandom_range(0, CHANNELS - 1));
            for (int i = 0; i < burst && sent < n_items; i++) begin
                if ($urandom_range(0, 1) == 1) chan = chan_t'($urandom_range(0, CHANNELS - 1));
                send_sample(random_sample(), chan);
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_valid <= 1'b0;
    endtask

    initial begin
        filter_sb   = new();
        cycle_count = 0;
        ready_mode  = READY_ALWAYS;
        ready_left  = 0;
        aresetn     = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = COEF_A0;
        cfg_data    = '0;
        s_valid     = 1'b0;
        s_sample_in = '0;
        s_chan_in   = '0;
        m_ready     = 1'b0;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // All gains are zero out of reset: extremes must come out as zero,
        // but they still land in the delay lines.
        send_sample(SMP_MAX, 3'd0);
        send_sample(SMP_MIN, 3'd7);
        send_sample('0, 3'd3);
        s_valid <= 1'b0;
        drain_results();

        // a0 = 0.5 on a fresh channel: exact halves round toward plus infinity
        choose_setting(SET_PASS);
        next_coefs[COEF_A0] = COEF_HALF;
        next_coefs[COEF_B4] = '0;
        load_coefs();
        send_sample(24'd1, 3'd1);
        send_sample(-24'sd1, 3'd1);
        send_sample(24'd3, 3'd1);
        send_sample(-24'sd3, 3'd1);
        send_sample(SMP_MAX, 3'd1);
        send_sample(SMP_MIN, 3'd1);
        s_valid <= 1'b0;
        drain_results();

        // Largest positive gains everywhere: drives both saturation limits
        foreach (next_coefs[i]) next_coefs[i] = COEF_MAX;
        load_coefs();
        send_sample(SMP_MAX, 3'd2);
        send_sample(SMP_MIN, 3'd2);
        send_sample(SMP_MAX, 3'd2);
        send_sample(SMP_MIN, 3'd2);
        s_valid <= 1'b0;
        drain_results();

        // Most negative gains everywhere
        foreach (next_coefs[i]) next_coefs[i] = COEF_MIN;
        load_coefs();
        send_sample(SMP_MIN, 3'd4);
        send_sample(SMP_MIN, 3'd4);
        send_sample(SMP_MAX, 3'd5);
        send_sample(SMP_MAX, 3'd6);
        s_valid <= 1'b0;
        drain_results();

        // Unity pass-through; the junk write to the spare index must not land
        choose_setting(SET_PASS);
        next_coefs[COEF_B4] = '0;
        load_coefs();
        send_sample(24'd12345, 3'd6);
        send_sample(SMP_MIN, 3'd7);
        send_sample(SMP_MAX, 3'd0);
        send_sample(-24'sd2, 3'd3);
        s_valid <= 1'b0;
        drain_results();

        // Random phases; each one pauses mid-way until the output has caught up
        for (int p = 0; p < 8; p++) begin
            choose_setting(coef_set_t'(p % 5));
            load_coefs();
            send_bursts(50);
            drain_results();
            send_bursts(50);
            drain_results();
        end

        if (filter_sb.mismatches == 0 && filter_sb.pending() == 0) begin
            $display("PASS linkwitz_riley4_lowpass");
        end else begin
            if (filter_sb.pending() != 0)
                $error("%0d expected output samples never arrived", filter_sb.pending());
            $display("FAIL linkwitz_riley4_lowpass");
        end
        $finish;
    end

endmodule
